[rtl/bphc_pkg.sv]
// Package for the button press/hold classifier: event and repeat codes,
// register map and the configuration struct. No dependencies.
package bphc_pkg;

    localparam int unsigned ADDR_W  = 4;
    localparam int unsigned DATA_W  = 32;
    localparam int unsigned TIME_W  = 32;
    localparam int unsigned HELD_W  = 16;
    localparam int unsigned EVENT_W = 3;
    localparam int unsigned REPT_W  = 2;

    // Event codes
    localparam logic [EVENT_W-1:0] EV_NONE         = 3'd0;
    localparam logic [EVENT_W-1:0] EV_PRESS        = 3'd1;
    localparam logic [EVENT_W-1:0] EV_HOLD         = 3'd2;
    localparam logic [EVENT_W-1:0] EV_HOLD_LONG    = 3'd3;
    localparam logic [EVENT_W-1:0] EV_RELEASE      = 3'd4;
    localparam logic [EVENT_W-1:0] EV_HOLD_RELEASE = 3'd5;

    // Sticky repeat class codes
    localparam logic [REPT_W-1:0] RP_NONE    = 2'd0;
    localparam logic [REPT_W-1:0] RP_PRESS   = 2'd1;
    localparam logic [REPT_W-1:0] RP_HOLD    = 2'd2;
    localparam logic [REPT_W-1:0] RP_RELEASE = 2'd3;

    // Register indexes (byte address = 4 * index)
    localparam logic [1:0] REG_HOLD_THR  = 2'd0;
    localparam logic [1:0] REG_LONG_THR  = 2'd1;
    localparam logic [1:0] REG_PRESS_LVL = 2'd2;

    localparam logic [HELD_W-1:0] HOLD_THR_RST = 16'd500;
    localparam logic [HELD_W-1:0] LONG_THR_RST = 16'd1000;
    localparam logic [HELD_W-1:0] HELD_MAX     = 16'hFFFF;

    typedef struct packed {
        logic [HELD_W-1:0] hold_thr;
        logic [HELD_W-1:0] long_thr;
        logic              pressed_level;
    } cfg_t;

endpackage

[rtl/button_press_hold_classifier.sv]
// Button press/hold classifier top level: poll register, classifier, result register.
// Poll register feeds result register; one item per cycle unless out_ready stalls.
// Rate is set by the single poll register feeding the classifier, whose state updates
// as each item moves into the result register. rst_n (async, active low) clears
// both valid flags, the press state and loads the threshold defaults 500 / 1000 ms.
// Depends on bphc_pkg, bphc_cfg, bphc_core.
module button_press_hold_classifier (
    input  logic                          clk,
    input  logic                          rst_n,
    // configuration port
    input  logic                          psel,
    input  logic                          penable,
    input  logic                          pwrite,
    input  logic [bphc_pkg::ADDR_W-1:0]   paddr,
    input  logic [bphc_pkg::DATA_W-1:0]   pwdata,
    output logic [bphc_pkg::DATA_W-1:0]   prdata,
    output logic                          pready,
    // poll input
    input  logic                          in_valid,
    output logic                          in_ready,
    input  logic                          pin_level,
    input  logic [bphc_pkg::TIME_W-1:0]   now_ms,
    // result output
    output logic                          out_valid,
    input  logic                          out_ready,
    output logic [bphc_pkg::EVENT_W-1:0]  event_res,
    output logic [bphc_pkg::REPT_W-1:0]   repeat_class
);
    import bphc_pkg::*;

    cfg_t cfg;

    // poll register
    logic              s1_valid_reg;
    logic              s1_pin_reg;
    logic [TIME_W-1:0] s1_now_reg;

    // result register
    logic               out_valid_reg;
    logic [EVENT_W-1:0] out_event_reg;
    logic [REPT_W-1:0]  out_repeat_reg;

    logic               out_free;
    logic               advance;
    logic               in_fire;
    logic [EVENT_W-1:0] core_event;
    logic [REPT_W-1:0]  core_repeat;

    bphc_cfg u_cfg (
        .clk     (clk),
        .rst_n   (rst_n),
        .psel    (psel),
        .penable (penable),
        .pwrite  (pwrite),
        .paddr   (paddr),
        .pwdata  (pwdata),
        .prdata  (prdata),
        .pready  (pready),
        .cfg     (cfg)
    );

    // The result register takes a new item when empty or being drained this cycle.
    assign out_free = !out_valid_reg || out_ready;
    // Retire the held poll into the result register; this also commits the state.
    assign advance  = s1_valid_reg && out_free;
    // Accept a new poll when the poll register is empty or retiring.
    assign in_ready = !s1_valid_reg || out_free;
    assign in_fire  = in_valid && in_ready;

    bphc_core u_core (
        .clk          (clk),
        .rst_n        (rst_n),
        .cfg          (cfg),
        .advance      (advance),
        .pin_level    (s1_pin_reg),
        .now_ms       (s1_now_reg),
        .event_res    (core_event),
        .repeat_class (core_repeat)
    );

    // Control flags
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            s1_valid_reg  <= 1'b0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            if (in_ready)
            begin
                s1_valid_reg <= in_valid;
            end
            if (out_free)
            begin
                out_valid_reg <= s1_valid_reg;
            end
        end
    end

    // Payload registers: hold until the next transfer
    always_ff @(posedge clk)
    begin
        if (in_fire)
        begin
            s1_pin_reg <= pin_level;
            s1_now_reg <= now_ms;
        end
        if (advance)
        begin
            out_event_reg  <= core_event;
            out_repeat_reg <= core_repeat;
        end
    end

    assign out_valid    = out_valid_reg;
    assign event_res    = out_event_reg;
    assign repeat_class = out_repeat_reg;

endmodule

[rtl/bphc_cfg.sv]
// Configuration register file behind the APB-style port.
// Depends on bphc_pkg.
module bphc_cfg (
    input  logic                         clk,
    input  logic                         rst_n,
    input  logic                         psel,
    input  logic                         penable,
    input  logic                         pwrite,
    input  logic [bphc_pkg::ADDR_W-1:0]  paddr,
    input  logic [bphc_pkg::DATA_W-1:0]  pwdata,
    output logic [bphc_pkg::DATA_W-1:0]  prdata,
    output logic                         pready,
    output bphc_pkg::cfg_t               cfg
);
    import bphc_pkg::*;

    cfg_t       cfg_reg;
    cfg_t       cfg_next;
    logic       wr_en;
    logic [1:0] reg_idx;

    assign pready  = 1'b1;
    assign wr_en   = psel && penable && pwrite;
    assign reg_idx = paddr[3:2];

    always_comb
    begin
        cfg_next = cfg_reg;
        if (wr_en)
        begin
            case (reg_idx)
                REG_HOLD_THR:  cfg_next.hold_thr      = pwdata[HELD_W-1:0];
                REG_LONG_THR:  cfg_next.long_thr      = pwdata[HELD_W-1:0];
                REG_PRESS_LVL: cfg_next.pressed_level = pwdata[0];
                default:       cfg_next = cfg_reg;
            endcase
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cfg_reg.hold_thr      <= HOLD_THR_RST;
            cfg_reg.long_thr      <= LONG_THR_RST;
            cfg_reg.pressed_level <= 1'b0;
        end
        else
        begin
            cfg_reg <= cfg_next;
        end
    end

    always_comb
    begin
        case (reg_idx)
            REG_HOLD_THR:  prdata = {{(DATA_W-HELD_W){1'b0}}, cfg_reg.hold_thr};
            REG_LONG_THR:  prdata = {{(DATA_W-HELD_W){1'b0}}, cfg_reg.long_thr};
            REG_PRESS_LVL: prdata = {{(DATA_W-1){1'b0}}, cfg_reg.pressed_level};
            default:       prdata = '0;
        endcase
    end

    assign cfg = cfg_reg;

endmodule

[rtl/bphc_core.sv]
// Classification logic and press state: turns one registered poll into an
// event and repeat class, and updates the state when the poll retires.
// Depends on bphc_pkg.
module bphc_core (
    input  logic                          clk,
    input  logic                          rst_n,
    input  bphc_pkg::cfg_t                cfg,
    input  logic                          advance,
    input  logic                          pin_level,
    input  logic [bphc_pkg::TIME_W-1:0]   now_ms,
    output logic [bphc_pkg::EVENT_W-1:0]  event_res,
    output logic [bphc_pkg::REPT_W-1:0]   repeat_class
);
    import bphc_pkg::*;

    logic              was_pressed_reg,  was_pressed_next;
    logic [TIME_W-1:0] start_reg,        start_next;
    logic [HELD_W-1:0] held_reg,         held_next;
    logic              hold_fired_reg,   hold_fired_next;
    logic              long_fired_reg,   long_fired_next;
    logic [REPT_W-1:0] repeat_reg,       repeat_next;

    logic              pressed;
    logic [TIME_W-1:0] elapsed;
    logic [HELD_W-1:0] held_sat;

    assign pressed  = (pin_level == cfg.pressed_level);
    assign elapsed  = now_ms - start_reg;
    assign held_sat = (elapsed[TIME_W-1:HELD_W] != '0) ? HELD_MAX : elapsed[HELD_W-1:0];

    always_comb
    begin
        was_pressed_next = pressed;
        start_next       = start_reg;
        held_next        = held_reg;
        hold_fired_next  = hold_fired_reg;
        long_fired_next  = long_fired_reg;
        repeat_next      = repeat_reg;
        event_res        = EV_NONE;

        if (!was_pressed_reg && pressed)
        begin
            event_res       = EV_PRESS;
            repeat_next     = RP_PRESS;
            start_next      = now_ms;
            held_next       = '0;
            hold_fired_next = 1'b0;
            long_fired_next = 1'b0;
        end
        else if (was_pressed_reg && pressed)
        begin
            held_next = held_sat;
            // long threshold wins when both are reached in one poll
            if (held_sat >= cfg.long_thr && !long_fired_reg)
            begin
                event_res       = EV_HOLD_LONG;
                repeat_next     = RP_HOLD;
                long_fired_next = 1'b1;
            end
            else if (held_sat >= cfg.hold_thr && !hold_fired_reg)
            begin
                event_res       = EV_HOLD;
                repeat_next     = RP_HOLD;
                hold_fired_next = 1'b1;
            end
        end
        else if (was_pressed_reg && !pressed)
        begin
            // judge on the held time of the last held poll
            event_res   = (held_reg <= cfg.hold_thr) ? EV_RELEASE : EV_HOLD_RELEASE;
            repeat_next = RP_RELEASE;
        end
    end

    assign repeat_class = repeat_next;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            was_pressed_reg <= 1'b0;
            start_reg       <= '0;
            held_reg        <= '0;
            hold_fired_reg  <= 1'b0;
            long_fired_reg  <= 1'b0;
            repeat_reg      <= RP_NONE;
        end
        else if (advance)
        begin
            was_pressed_reg <= was_pressed_next;
            start_reg       <= start_next;
            held_reg        <= held_next;
            hold_fired_reg  <= hold_fired_next;
            long_fired_reg  <= long_fired_next;
            repeat_reg      <= repeat_next;
        end
    end

endmodule

[rtl/bphc_checker.sv]
// Port-level checker for the button press/hold classifier, bound to the top level.
// Depends on bphc_pkg and button_press_hold_classifier.
module bphc_checker (
    input logic                          clk,
    input logic                          rst_n,
    input logic                          in_ready,
    input logic                          out_valid,
    input logic                          out_ready,
    input logic [bphc_pkg::EVENT_W-1:0]  event_res,
    input logic [bphc_pkg::REPT_W-1:0]   repeat_class
);
    import bphc_pkg::*;

    // A stalled item keeps its payload.
    a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && !out_ready |=> out_valid && $stable(event_res) && $stable(repeat_class))
        else $error("result changed while stalled");

    // Only defined event codes appear.
    a_event_code: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid |-> (event_res == EV_NONE || event_res == EV_PRESS ||
                       event_res == EV_HOLD || event_res == EV_HOLD_LONG ||
                       event_res == EV_RELEASE || event_res == EV_HOLD_RELEASE))
        else $error("undefined event code");

    // The repeat class follows the event of the same item.
    a_repeat_match: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && event_res != EV_NONE |->
            ((event_res == EV_PRESS && repeat_class == RP_PRESS) ||
             ((event_res == EV_HOLD || event_res == EV_HOLD_LONG) && repeat_class == RP_HOLD) ||
             ((event_res == EV_RELEASE || event_res == EV_HOLD_RELEASE) &&
              repeat_class == RP_RELEASE)))
        else $error("repeat class does not match event");

    // With no result pending the block must take input.
    a_ready_when_empty: assert property (@(posedge clk) disable iff (!rst_n)
        !out_valid |-> in_ready)
        else $error("input stalled with empty output");

endmodule

bind button_press_hold_classifier bphc_checker u_bphc_checker (
    .clk          (clk),
    .rst_n        (rst_n),
    .in_ready     (in_ready),
    .out_valid    (out_valid),
    .out_ready    (out_ready),
    .event_res    (event_res),
    .repeat_class (repeat_class)
);

[test/button_event_checker.sv]
// Result checker for the button press/hold classifier: mirrors the register file,
// predicts one event and repeat class per accepted poll and compares them in order.
// Depends on bphc_pkg.
module button_event_checker (
    input  logic                          clk,
    input  logic                          rst_n,
    input  logic                          psel,
    input  logic                          penable,
    input  logic                          pwrite,
    input  logic                          pready,
    input  logic [bphc_pkg::ADDR_W-1:0]   paddr,
    input  logic [bphc_pkg::DATA_W-1:0]   pwdata,
    input  logic                          in_valid,
    input  logic                          in_ready,
    input  logic                          pin_level,
    input  logic [bphc_pkg::TIME_W-1:0]   now_ms,
    input  logic                          out_valid,
    input  logic                          out_ready,
    input  logic [bphc_pkg::EVENT_W-1:0]  event_res,
    input  logic [bphc_pkg::REPT_W-1:0]   repeat_class,
    output int                            mismatch_count,
    output int                            pending_count
);
    import bphc_pkg::*;

    typedef struct packed {
        logic [EVENT_W-1:0] ev;
        logic [REPT_W-1:0]  rp;
    } button_result_t;

    // register copy
    logic [HELD_W-1:0] cfg_hold;
    logic [HELD_W-1:0] cfg_long;
    logic              cfg_level;

    // button state copy
    logic              btn_down;
    logic [TIME_W-1:0] btn_start;
    logic [HELD_W-1:0] btn_held;
    logic              hold_done;
    logic              long_done;
    logic [REPT_W-1:0] last_class;

    button_result_t expected_events[$];
    int             reported;

    function automatic button_result_t classify_poll(input logic lvl,
                                                     input logic [TIME_W-1:0] now);
        button_result_t    res;
        logic              pressed;
        logic [TIME_W-1:0] elapsed;
        pressed = (lvl == cfg_level);
        elapsed = now - btn_start;
        res.ev  = EV_NONE;
        if (!btn_down && pressed)
        begin
            res.ev     = EV_PRESS;
            last_class = RP_PRESS;
            btn_start  = now;
            btn_held   = '0;
            hold_done  = 1'b0;
            long_done  = 1'b0;
        end
        else if (btn_down && pressed)
        begin
            // saturate the wrap-safe elapsed time
            btn_held = (elapsed[TIME_W-1:HELD_W] != '0) ? HELD_MAX : elapsed[HELD_W-1:0];
            if (btn_held >= cfg_long && !long_done)
            begin
                res.ev     = EV_HOLD_LONG;
                last_class = RP_HOLD;
                long_done  = 1'b1;
            end
            else if (btn_held >= cfg_hold && !hold_done)
            begin
                res.ev     = EV_HOLD;
                last_class = RP_HOLD;
                hold_done  = 1'b1;
            end
        end
        else if (btn_down && !pressed)
        begin
            res.ev     = (btn_held <= cfg_hold) ? EV_RELEASE : EV_HOLD_RELEASE;
            last_class = RP_RELEASE;
        end
        btn_down = pressed;
        res.rp   = last_class;
        return res;
    endfunction

    always @(posedge clk or negedge rst_n)
    begin : track
        button_result_t want;
        if (!rst_n)
        begin
            cfg_hold       = HOLD_THR_RST;
            cfg_long       = LONG_THR_RST;
            cfg_level      = 1'b0;
            btn_down       = 1'b0;
            btn_start      = '0;
            btn_held       = '0;
            hold_done      = 1'b0;
            long_done      = 1'b0;
            last_class     = RP_NONE;
            reported       = 0;
            mismatch_count = 0;
            expected_events.delete();
        end
        else
        begin
            if (psel && penable && pwrite && pready)
            begin
                case (paddr[ADDR_W-1:2])
                    REG_HOLD_THR:  cfg_hold  = pwdata[HELD_W-1:0];
                    REG_LONG_THR:  cfg_long  = pwdata[HELD_W-1:0];
                    REG_PRESS_LVL: cfg_level = pwdata[0];
                    default: ;
                endcase
            end
            // retire the result before queuing a new poll taken at the same edge
            if (out_valid && out_ready)
            begin
                if (expected_events.size() == 0)
                begin
                    mismatch_count++;
                    if (reported < 10)
                    begin
                        reported++;
                        $display("unexpected result: event %0d repeat %0d",
                                 event_res, repeat_class);
                    end
                end
                else
                begin
                    want = expected_events.pop_front();
                    if (event_res !== want.ev || repeat_class !== want.rp)
                    begin
                        mismatch_count++;
                        if (reported < 10)
                        begin
                            reported++;
                            $display("mismatch: exp event %0d repeat %0d, got %0d %0d",
                                     want.ev, want.rp, event_res, repeat_class);
                        end
                    end
                end
            end
            if (in_valid && in_ready)
                expected_events.push_back(classify_poll(pin_level, now_ms));
        end
        pending_count = expected_events.size();
    end

endmodule

[test/testbench.sv]
// Top of the button press/hold classifier test: clock, reset, register writes,
// poll stimulus with random gaps and the verdict.
// Depends on bphc_pkg, button_press_hold_classifier and button_event_checker.
module testbench;
    import bphc_pkg::*;

    localparam int unsigned CHOKE_CYCLES = 300;
    localparam logic [ADDR_W-1:0] HOLD_ADDR  = {REG_HOLD_THR, 2'b00};
    localparam logic [ADDR_W-1:0] LONG_ADDR  = {REG_LONG_THR, 2'b00};
    localparam logic [ADDR_W-1:0] LEVEL_ADDR = {REG_PRESS_LVL, 2'b00};
    // first address past the register map; writes there must be ignored
    localparam logic [ADDR_W-1:0] SPARE_ADDR = 4'hC;

    logic                clk;
    logic                rst_n;
    logic                psel;
    logic                penable;
    logic                pwrite;
    logic [ADDR_W-1:0]   paddr;
    logic [DATA_W-1:0]   pwdata;
    logic [DATA_W-1:0]   prdata;
    logic                pready;
    logic                in_valid;
    logic                in_ready;
    logic                pin_level;
    logic [TIME_W-1:0]   now_ms;
    logic                out_valid;
    logic                out_ready;
    logic [EVENT_W-1:0]  event_res;
    logic [REPT_W-1:0]   repeat_class;

    int                  mismatch_count;
    int                  pending_count;

    // settings as last written, used to shape well-formed press sequences
    logic [HELD_W-1:0]   cfg_hold;
    logic [HELD_W-1:0]   cfg_long;
    logic                cfg_lvl;

    // timeline of the simulated millisecond counter and the press script
    logic [TIME_W-1:0]   timeline_ms;
    logic                want_pressed;
    int unsigned         run_left;

    // calm turns off idling on both sides; choke_req asks the receiver for a long hold-off
    logic                calm;
    logic                choke_req;

    button_press_hold_classifier DUT (
        .clk          (clk),
        .rst_n        (rst_n),
        .psel         (psel),
        .penable      (penable),
        .pwrite       (pwrite),
        .paddr        (paddr),
        .pwdata       (pwdata),
        .prdata       (prdata),
        .pready       (pready),
        .in_valid     (in_valid),
        .in_ready     (in_ready),
        .pin_level    (pin_level),
        .now_ms       (now_ms),
        .out_valid    (out_valid),
        .out_ready    (out_ready),
        .event_res    (event_res),
        .repeat_class (repeat_class)
    );

    button_event_checker events_chk (
        .clk            (clk),
        .rst_n          (rst_n),
        .psel           (psel),
        .penable        (penable),
        .pwrite         (pwrite),
        .pready         (pready),
        .paddr          (paddr),
        .pwdata         (pwdata),
        .in_valid       (in_valid),
        .in_ready       (in_ready),
        .pin_level      (pin_level),
        .now_ms         (now_ms),
        .out_valid      (out_valid),
        .out_ready      (out_ready),
        .event_res      (event_res),
        .repeat_class   (repeat_class),
        .mismatch_count (mismatch_count),
        .pending_count  (pending_count)
    );

    initial
    begin
        clk = 1'b0;
        forever #4 clk = ~clk;
    end

    // Hard stop well beyond the slowest legal run.
    initial
    begin
        #5000000;
        $display("testbench: FAIL");
        $finish;
    end

    // Idle length: mostly none or short, now and then a long one.
    function automatic int unsigned pick_gap();
        int unsigned r;
        if (calm)
            return 0;
        r = $urandom_range(99);
        if (r < 50)
            return 0;
        if (r < 85)
            return $urandom_range(3, 1);
        if (r < 97)
            return $urandom_range(10, 4);
        return $urandom_range(60, 20);
    endfunction

    // Receiver: drive out_ready at the falling edge, stall at random, and
    // honor one long hold-off so the block backs up into its input.
    initial
    begin : receiver
        int unsigned stall;
        logic        choked;
        out_ready = 1'b0;
        choked    = 1'b0;
        @(posedge rst_n);
        forever
        begin
            @(negedge clk);
            if (choke_req && !choked)
            begin
                choked = 1'b1;
                out_ready <= 1'b0;
                repeat (CHOKE_CYCLES) @(negedge clk);
            end
            stall = pick_gap();
            if (stall != 0)
            begin
                out_ready <= 1'b0;
                repeat (stall) @(negedge clk);
            end
            out_ready <= 1'b1;
            repeat ($urandom_range(8, 1) - 1) @(negedge clk);
        end
    end

    // One APB write: setup phase, then access until pready. Drop psel and
    // stay idle after, so back-to-back writes never retarget psel in one step.
    task automatic write_reg(input logic [ADDR_W-1:0] addr, input logic [DATA_W-1:0] data);
        psel    <= 1'b1;
        pwrite  <= 1'b1;
        penable <= 1'b0;
        paddr   <= addr;
        pwdata  <= data;
        @(negedge clk);
        penable <= 1'b1;
        @(posedge clk);
        while (!pready) @(posedge clk);
        @(negedge clk);
        psel    <= 1'b0;
        penable <= 1'b0;
        pwrite  <= 1'b0;
        @(negedge clk);
    endtask

    // Drop valid and hold until every queued poll has produced its result.
    task automatic wait_drained();
        in_valid <= 1'b0;
        @(negedge clk);
        while (pending_count != 0) @(negedge clk);
    endtask

    // Reprogram all three registers on an idle block; keep the masked copy.
    task automatic apply_settings(input logic [DATA_W-1:0] hold_word,
                                  input logic [DATA_W-1:0] long_word,
                                  input logic [DATA_W-1:0] lvl_word);
        wait_drained();
        write_reg(HOLD_ADDR, hold_word);
        write_reg(LONG_ADDR, long_word);
        write_reg(LEVEL_ADDR, lvl_word);
        cfg_hold = hold_word[HELD_W-1:0];
        cfg_long = long_word[HELD_W-1:0];
        cfg_lvl  = lvl_word[0];
    endtask

    // Offer one poll and hold it until taken. Valid stays up when the next
    // poll follows with no gap.
    task automatic send_poll(input logic lvl, input logic [TIME_W-1:0] t);
        int unsigned gap;
        in_valid  <= 1'b1;
        pin_level <= lvl;
        now_ms    <= t;
        @(posedge clk);
        while (!in_ready) @(posedge clk);
        @(negedge clk);
        gap = pick_gap();
        if (gap != 0)
        begin
            in_valid <= 1'b0;
            repeat (gap) @(negedge clk);
        end
    endtask

    // Random polls: mostly press/hold/release runs on an advancing timeline
    // scaled to the thresholds, with some noise polls at arbitrary times.
    task automatic run_polls(input int unsigned count);
        int unsigned n;
        int unsigned span;
        int unsigned delta;
        int unsigned r;
        logic        lvl;
        span = ((cfg_hold > cfg_long) ? cfg_hold : cfg_long) + 8;
        for (n = 0; n < count; n++)
        begin
            if ($urandom_range(99) < 12)
            begin
                lvl         = 1'($urandom_range(1, 0));
                timeline_ms = $urandom();
            end
            else
            begin
                if (run_left == 0)
                begin
                    want_pressed = !want_pressed;
                    run_left     = want_pressed ? $urandom_range(6, 1) : $urandom_range(3, 1);
                end
                run_left--;
                r = $urandom_range(99);
                if (r < 5)
                begin
                    // jump close to the counter wrap
                    timeline_ms = 32'hFFFF_FFFF - $urandom_range(span, 0);
                end
                else
                begin
                    if (r < 15)
                        delta = 0;
                    else if (r < 75)
                        delta = $urandom_range(span / 2, 0);
                    else if (r < 93)
                        delta = $urandom_range(span + span / 4, 0);
                    else
                        delta = $urandom_range(80000, 0);
                    timeline_ms = timeline_ms + delta;
                end
                lvl = want_pressed ? cfg_lvl : !cfg_lvl;
            end
            send_poll(lvl, timeline_ms);
        end
    endtask

    initial
    begin
        rst_n        = 1'b0;
        psel         = 1'b0;
        penable      = 1'b0;
        pwrite       = 1'b0;
        paddr        = '0;
        pwdata       = '0;
        in_valid     = 1'b0;
        pin_level    = 1'b0;
        now_ms       = '0;
        calm         = 1'b0;
        choke_req    = 1'b0;
        cfg_hold     = HOLD_THR_RST;
        cfg_long     = LONG_THR_RST;
        cfg_lvl      = 1'b0;
        timeline_ms  = '0;
        want_pressed = 1'b0;
        run_left     = 0;
        repeat (7) @(negedge clk);
        rst_n <= 1'b1;
        @(negedge clk);

        // Directed, reset thresholds 500 / 1000, pressed at level 0.
        send_poll(1'b1, 32'h0000_0000);    // released: no event
        send_poll(1'b0, 32'hFFFF_FF00);    // press just before the counter wraps
        send_poll(1'b0, 32'h0000_0100);    // 512 ms across the wrap: hold
        send_poll(1'b0, 32'h0000_0300);    // 1024 ms: long hold
        send_poll(1'b1, 32'h0000_0400);    // release after hold
        send_poll(1'b1, 32'h0000_0500);
        send_poll(1'b0, 32'd1000);         // press
        send_poll(1'b1, 32'd1001);         // release right after press sees 0 ms
        send_poll(1'b0, 32'd2000);
        send_poll(1'b0, 32'd2500);         // exactly the hold threshold
        send_poll(1'b1, 32'd2600);         // held equal to threshold: plain release
        send_poll(1'b0, 32'hFFFF_FFFF);
        send_poll(1'b0, 32'd70000);        // elapsed saturates, both reached: long only
        send_poll(1'b0, 32'd70001);        // hold fires on the next poll
        send_poll(1'b0, 32'd70002);        // nothing left to fire

        // Flip the pressed level while the button is held: next poll is a release.
        apply_settings(32'd2000, 32'd100, 32'd1);
        send_poll(1'b0, 32'd80000);
        send_poll(1'b1, 32'h8000_0000);    // long threshold below hold threshold
        send_poll(1'b1, 32'h8000_0064);
        send_poll(1'b1, 32'h8000_07D0);
        send_poll(1'b0, 32'h8000_0800);

        // Zero thresholds through words with upper bits set; poke a hole in the map.
        apply_settings(32'hFFFF_0000, 32'hABCD_0000, 32'hFFFF_FFFF);
        write_reg(SPARE_ADDR, 32'hFFFF_FFFF);
        send_poll(1'b1, 32'h1234_5678);
        send_poll(1'b1, 32'h1234_5678);
        send_poll(1'b1, 32'h1234_5678);
        send_poll(1'b0, 32'h1234_5679);

        // Top thresholds; ask for the long receiver hold-off while polls keep coming.
        apply_settings(32'd65535, 32'd65535, 32'd0);
        choke_req = 1'b1;
        run_polls(75);

        // Reset-like thresholds with one full drain in the middle of the phase.
        apply_settings(32'd500, 32'd1000, 32'd0);
        run_polls(40);
        wait_drained();
        run_polls(35);

        // Random thresholds, no idling on either side.
        apply_settings($urandom_range(3000, 0), $urandom_range(3000, 0), $urandom_range(1, 0));
        calm = 1'b1;
        run_polls(75);
        calm = 1'b0;

        apply_settings(32'd100, 32'd50, 32'd1);
        run_polls(75);

        apply_settings($urandom(), $urandom(), $urandom());
        run_polls(75);

        apply_settings($urandom_range(300, 0), $urandom_range(300, 0), $urandom_range(1, 0));
        run_polls(75);

        // Drain, then give the two-stage pipe time to show any stray result.
        wait_drained();
        repeat (10) @(negedge clk);
        if (mismatch_count == 0 && pending_count == 0)
            $display("testbench: PASS");
        else
            $display("testbench: FAIL");
        $finish;
    end

endmodule

[filelist.f]
rtl/bphc_pkg.sv
rtl/bphc_cfg.sv
rtl/bphc_core.sv
rtl/button_press_hold_classifier.sv
rtl/bphc_checker.sv
test/button_event_checker.sv
test/testbench.sv
